// ===== sv/nec_pkg.sv =====
// ----------------------------------------------------------------------------
// nec_pkg
// Shared widths, reset values and operation codes of the epsilon closure block.
// ----------------------------------------------------------------------------
package nec_pkg;

    localparam int DEF_NUM_STATES = 64;
    localparam int SYM_W          = 9;
    localparam int STATE_FIELD_W  = 6;
    localparam int SET_W          = 64;

    localparam logic [SYM_W-1:0] EPS_RESET = 9'd256;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

endpackage

// ===== sv/nec_cfg_if.sv =====
// ----------------------------------------------------------------------------
// nec_cfg_if
// Write channel for the epsilon symbol register.
// ----------------------------------------------------------------------------
interface nec_cfg_if;

    logic                      valid;
    logic                      ready;
    logic [nec_pkg::SYM_W-1:0] epsilon_symbol;

    modport source (output valid, output epsilon_symbol, input ready);
    modport sink   (input valid, input epsilon_symbol, output ready);

endinterface

// ===== sv/nec_item_if.sv =====
// ----------------------------------------------------------------------------
// nec_item_if
// Input item channel: add an edge or query an epsilon closure.
// ----------------------------------------------------------------------------
interface nec_item_if;

    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic [nec_pkg::STATE_FIELD_W-1:0] source_state;
    logic [nec_pkg::SYM_W-1:0]         edge_symbol;
    logic [nec_pkg::STATE_FIELD_W-1:0] target_state;
    logic [nec_pkg::SET_W-1:0]         seed_set;

    modport source (output valid, output operation, output source_state,
                    output edge_symbol, output target_state, output seed_set,
                    input ready);
    modport sink   (input valid, input operation, input source_state,
                    input edge_symbol, input target_state, input seed_set,
                    output ready);

endinterface

// ===== sv/nec_result_if.sv =====
// ----------------------------------------------------------------------------
// nec_result_if
// Result channel carrying one closure set per query.
// ----------------------------------------------------------------------------
interface nec_result_if;

    logic                      valid;
    logic                      ready;
    logic [nec_pkg::SET_W-1:0] closure_set;

    modport source (output valid, output closure_set, input ready);
    modport sink   (input valid, input closure_set, output ready);

endinterface

// ===== sv/nec_adj_mem.sv =====
// ----------------------------------------------------------------------------
// nec_adj_mem
// Epsilon adjacency memory, one row per state, with a registered
// read. Per-row valid flags cleared at reset make unwritten rows read as zero.
// ----------------------------------------------------------------------------
module nec_adj_mem #(
    parameter int NUM_STATES = nec_pkg::DEF_NUM_STATES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [$clog2(NUM_STATES)-1:0] i_rd_addr,
    output logic [NUM_STATES-1:0]         o_rd_row,
    input  logic                          i_wr_en,
    input  logic [$clog2(NUM_STATES)-1:0] i_wr_addr,
    input  logic [NUM_STATES-1:0]         i_wr_data
);
    import nec_pkg::*;

    logic [NUM_STATES-1:0] r_mem [NUM_STATES];
    logic [NUM_STATES-1:0] r_row_vld;
    logic [NUM_STATES-1:0] r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_row_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_row = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== sv/nec_pick.sv =====
// ----------------------------------------------------------------------------
// nec_pick
// Finds the lowest pending state in a set so that its row is read next.
// ----------------------------------------------------------------------------
module nec_pick #(
    parameter int NUM_STATES = nec_pkg::DEF_NUM_STATES
) (
    input  logic [NUM_STATES-1:0]         i_set,
    output logic [$clog2(NUM_STATES)-1:0] o_idx,
    output logic                          o_any
);
    import nec_pkg::*;

    localparam int SW = $clog2(NUM_STATES);

    always_comb begin
        o_idx = '0;
        for (int i = NUM_STATES - 1; i >= 0; i--) begin
            if (i_set[i]) begin
                o_idx = SW'(i);
            end
        end
    end

    assign o_any = |i_set;

endmodule

// ===== sv/nfa_epsilon_closure.sv =====
// ----------------------------------------------------------------------------
// nfa_epsilon_closure
// Epsilon adjacency store over NFA states with closure queries.
// ----------------------------------------------------------------------------
// Items arrive on i_item. An add beat whose symbol equals the epsilon symbol
// register, and whose states are in range, sets one bit of the adjacency row
// of its source state by a row read, then a write back; any other add beat
// changes nothing.
// A query beat reads the row of every seed and every newly reached state
// exactly once, one row per cycle through the single read port. Once no
// row is pending or in flight, the walk ends and the result register is
// loaded from the set of reached states.
// Results leave on o_result from an output register, so add beats are taken
// while a result waits. A query that finishes while the previous result is
// still stalled waits until the register frees.
// The epsilon symbol is written on i_cfg, which is always ready. Reset clears
// all edges at once through per-row valid flags and sets the symbol to 256.
// ----------------------------------------------------------------------------
module nfa_epsilon_closure #(
    parameter int NUM_STATES = nec_pkg::DEF_NUM_STATES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nec_cfg_if.sink       i_cfg,
    nec_item_if.sink      i_item,
    nec_result_if.source  o_result
);
    import nec_pkg::*;

    localparam int SW = $clog2(NUM_STATES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD_WR,
        S_WALK,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [SYM_W-1:0]      r_eps, n_eps;
    logic [SW-1:0]         r_src, n_src;
    logic [SW-1:0]         r_dst, n_dst;
    logic [NUM_STATES-1:0] r_pend, n_pend;
    logic [NUM_STATES-1:0] r_seen, n_seen;
    logic [NUM_STATES-1:0] r_clos, n_clos;
    logic                  r_inflight, n_inflight;
    logic                  r_out_vld, n_out_vld;
    logic [SET_W-1:0]      r_out_data, n_out_data;

    logic                  mem_rd_en;
    logic [SW-1:0]         mem_rd_addr;
    logic [NUM_STATES-1:0] mem_rd_row;
    logic                  mem_wr_en;
    logic [NUM_STATES-1:0] mem_wr_data;
    logic [SW-1:0]         pick_idx;
    logic                  pick_any;
    logic [NUM_STATES-1:0] w_new;
    logic [NUM_STATES-1:0] w_issued;
    logic                  in_fire;
    logic                  add_ok;
    logic                  out_free;

    nec_adj_mem #(
        .NUM_STATES (NUM_STATES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_row  (mem_rd_row),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_src),
        .i_wr_data (mem_wr_data)
    );

    nec_pick #(
        .NUM_STATES (NUM_STATES)
    ) u_pick (
        .i_set (r_pend),
        .o_idx (pick_idx),
        .o_any (pick_any)
    );

    assign i_cfg.ready         = 1'b1;
    assign i_item.ready        = (r_state == S_IDLE);
    assign o_result.valid      = r_out_vld;
    assign o_result.closure_set = r_out_data;

    assign in_fire  = i_item.valid && i_item.ready;
    assign add_ok   = (i_item.operation == OP_ADD) && (i_item.edge_symbol == r_eps) &&
                      (int'(i_item.source_state) < NUM_STATES) &&
                      (int'(i_item.target_state) < NUM_STATES);
    assign out_free = !r_out_vld || o_result.ready;

    assign w_new       = r_inflight ? mem_rd_row : '0;
    assign w_issued    = pick_any ? (NUM_STATES'(1) << pick_idx) : '0;
    assign mem_wr_data = mem_rd_row | (NUM_STATES'(1) << r_dst);

    always_comb begin
        n_state     = r_state;
        n_eps       = r_eps;
        n_src       = r_src;
        n_dst       = r_dst;
        n_pend      = r_pend;
        n_seen      = r_seen;
        n_clos      = r_clos;
        n_inflight  = r_inflight;
        n_out_vld   = r_out_vld;
        n_out_data  = r_out_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = pick_idx;
        mem_wr_en   = 1'b0;

        if (i_cfg.valid) begin
            n_eps = i_cfg.epsilon_symbol;
        end
        if (r_out_vld && o_result.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_item.operation == OP_QUERY) begin
                        n_pend     = i_item.seed_set[NUM_STATES-1:0];
                        n_seen     = i_item.seed_set[NUM_STATES-1:0];
                        n_clos     = '0;
                        n_inflight = 1'b0;
                        n_state    = S_WALK;
                    end else if (add_ok) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = i_item.source_state[SW-1:0];
                        n_src       = i_item.source_state[SW-1:0];
                        n_dst       = i_item.target_state[SW-1:0];
                        n_state     = S_ADD_WR;
                    end
                end
            end
            S_ADD_WR: begin
                mem_wr_en = 1'b1;
                n_state   = S_IDLE;
            end
            S_WALK: begin
                mem_rd_en  = pick_any;
                n_pend     = (r_pend & ~w_issued) | (w_new & ~r_seen);
                n_seen     = r_seen | w_new;
                n_clos     = r_clos | w_new;
                n_inflight = pick_any;
                if (!pick_any && !r_inflight) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_data = SET_W'(r_clos);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_eps      <= EPS_RESET;
            r_inflight <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_eps      <= n_eps;
            r_inflight <= n_inflight;
            r_out_vld  <= n_out_vld;
        end
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_pend     <= n_pend;
        r_seen     <= n_seen;
        r_clos     <= n_clos;
        r_out_data <= n_out_data;
    end

`ifndef SYNTH
    a_pend_in_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_pend & ~r_seen) == '0))
        else $error("pending state not marked as seen");

    a_clos_in_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_clos & ~r_seen) == '0))
        else $error("reached state not marked as seen");

    a_walk_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) && (n_state != S_WALK) |-> (r_pend == '0) && !r_inflight)
        else $error("walk ended with rows still pending");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_WR) |-> $past(mem_rd_en))
        else $error("row written back without a preceding read");
`endif

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the NFA epsilon closure block.
// ----------------------------------------------------------------------------
// A short table of directed items runs first under the reset epsilon code.
// Random phases follow, each under an epsilon code written at its start.
// Results are checked against the table's expected sets or a software copy
// of the adjacency matrix. Item sender and result receiver idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import nec_pkg::*;

    localparam int NUM_STATES  = DEF_NUM_STATES;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 90;
    localparam int DIR_ROWS    = 22;

    localparam logic [SET_W-1:0] ALL_SET = {SET_W{1'b1}};
    localparam logic [SET_W-1:0] NO_SET  = '0;

    typedef struct {
        t_op                      op;
        logic [STATE_FIELD_W-1:0] src;
        logic [SYM_W-1:0]         sym;
        logic [STATE_FIELD_W-1:0] tgt;
        logic [SET_W-1:0]         seed;
        bit                       typed;
        logic [SET_W-1:0]         closure;
    } t_dir_row;

    logic clk;
    logic rst_n;

    nec_cfg_if    cfg_bus ();
    nec_item_if   item_bus ();
    nec_result_if result_bus ();

    nfa_epsilon_closure dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_cfg    (cfg_bus),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    logic [SET_W-1:0] eps_rows [NUM_STATES];
    logic [SYM_W-1:0] eps_code;
    logic [SET_W-1:0] pending_closures [$];
    t_dir_row         directed_rows [DIR_ROWS];

    bit steady;
    int mismatch_count;
    int items_sent;
    int queries_sent;
    int eps_beats;
    int results_checked;
    int codes_used;
    int stall_left;
    int quiet_cycles;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [SET_W-1:0] closure_of(input logic [SET_W-1:0] seed);
        logic [SET_W-1:0] frontier;
        logic [SET_W-1:0] reached;
        logic [SET_W-1:0] next_set;
        frontier = seed;
        reached  = '0;
        while (frontier != '0) begin
            next_set = '0;
            for (int s = 0; s < NUM_STATES; s++) begin
                if (frontier[s]) begin
                    next_set |= eps_rows[s];
                end
            end
            frontier = next_set & ~reached;
            reached |= next_set;
        end
        return reached;
    endfunction

    task automatic send_item(input t_op op, input logic [STATE_FIELD_W-1:0] src,
                             input logic [SYM_W-1:0] sym,
                             input logic [STATE_FIELD_W-1:0] tgt,
                             input logic [SET_W-1:0] seed, input bit typed,
                             input logic [SET_W-1:0] typed_closure);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid        <= 1'b1;
        item_bus.operation    <= op;
        item_bus.source_state <= src;
        item_bus.edge_symbol  <= sym;
        item_bus.target_state <= tgt;
        item_bus.seed_set     <= seed;
        @(posedge clk);
        while (!item_bus.ready) @(posedge clk);
        items_sent++;
        if (op == OP_ADD) begin
            if (sym == eps_code) begin
                eps_rows[src][tgt] = 1'b1;
                eps_beats++;
            end
        end else begin
            queries_sent++;
            pending_closures.insert(pending_closures.size(),
                                    typed ? typed_closure : closure_of(seed));
        end
    endtask

    // The register is only written once the block has drained; an add beat
    // may still be in flight after the last result, hence the extra cycles.
    task automatic write_eps(input logic [SYM_W-1:0] code);
        item_bus.valid <= 1'b0;
        while (pending_closures.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_bus.valid          <= 1'b1;
        cfg_bus.epsilon_symbol <= code;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        cfg_bus.valid <= 1'b0;
        eps_code = code;
        codes_used++;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            stall_left = 0;
            result_bus.ready <= 1'b0;
        end else begin
            if (result_bus.valid && result_bus.ready) begin
                if (pending_closures.size() == 0) begin
                    $display("%0t: unexpected closure beat, expected none, actual %h",
                             $time, result_bus.closure_set);
                    mismatch_count++;
                end else begin
                    if (result_bus.closure_set !== pending_closures[0]) begin
                        $display("%0t: closure_set mismatch, expected %h, actual %h",
                                 $time, pending_closures[0], result_bus.closure_set);
                        mismatch_count++;
                    end
                    void'(pending_closures.pop_front());
                    results_checked++;
                end
                stall_left = steady ? 0 : $urandom_range(0, 7);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            result_bus.ready <= (stall_left == 0);
        end
    end

    always @(posedge clk) begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d closures outstanding",
                     $time, QUIET_LIMIT, pending_closures.size());
            $display("nfa_epsilon_closure test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [SYM_W-1:0]         code;
        logic [STATE_FIELD_W-1:0] src;
        logic [STATE_FIELD_W-1:0] tgt;
        logic [SYM_W-1:0]         sym;
        logic [SET_W-1:0]         seed;
        int                       kind;

        rst_n                  <= 1'b0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.epsilon_symbol <= '0;
        item_bus.valid         <= 1'b0;
        item_bus.operation     <= OP_ADD;
        item_bus.source_state  <= '0;
        item_bus.edge_symbol   <= '0;
        item_bus.target_state  <= '0;
        item_bus.seed_set      <= '0;
        mismatch_count         = 0;
        items_sent             = 0;
        queries_sent           = 0;
        eps_beats              = 0;
        results_checked        = 0;
        codes_used             = 1;
        steady                 = 1'b0;
        eps_code               = EPS_RESET;
        for (int s = 0; s < NUM_STATES; s++) begin
            eps_rows[s] = '0;
        end

        directed_rows = '{
            '{OP_QUERY, 6'd0,  9'd0,      6'd0,  ALL_SET, 1'b1, NO_SET},
            '{OP_QUERY, 6'd63, 9'd511,    6'd63, NO_SET,  1'b1, NO_SET},
            '{OP_ADD,   6'd0,  EPS_RESET, 6'd63, NO_SET,  1'b0, NO_SET},
            '{OP_ADD,   6'd63, 9'd255,    6'd0,  NO_SET,  1'b0, NO_SET},
            '{OP_ADD,   6'd63, 9'd511,    6'd0,  NO_SET,  1'b0, NO_SET},
            '{OP_ADD,   6'd63, 9'd0,      6'd0,  NO_SET,  1'b0, NO_SET},
            '{OP_QUERY, 6'd0,  9'd0,      6'd0,  64'd1,   1'b1, 64'd1 << 63},
            '{OP_QUERY, 6'd0,  9'd0,      6'd0,  64'd1 << 63, 1'b1, NO_SET},
            '{OP_ADD,   6'd63, EPS_RESET, 6'd0,  ALL_SET, 1'b0, NO_SET},
            '{OP_QUERY, 6'd0,  9'd0,      6'd0,  64'd1,   1'b1, (64'd1 << 63) | 64'd1},
            '{OP_ADD,   6'd0,  EPS_RESET, 6'd63, NO_SET,  1'b0, NO_SET},
            '{OP_QUERY, 6'd0,  9'd0,      6'd0,  64'd1 << 63, 1'b1,
              (64'd1 << 63) | 64'd1},
            '{OP_ADD,   6'd5,  EPS_RESET, 6'd5,  NO_SET,  1'b0, NO_SET},
            '{OP_QUERY, 6'd63, 9'd511,    6'd63, 64'd1 << 5, 1'b1, 64'd1 << 5},
            '{OP_ADD,   6'd10, EPS_RESET, 6'd11, NO_SET,  1'b0, NO_SET},
            '{OP_ADD,   6'd11, EPS_RESET, 6'd12, NO_SET,  1'b0, NO_SET},
            '{OP_QUERY, 6'd0,  9'd0,      6'd0,  64'd1 << 10, 1'b1,
              (64'd1 << 11) | (64'd1 << 12)},
            '{OP_QUERY, 6'd0,  9'd0,      6'd0,  ALL_SET, 1'b1,
              (64'd1 << 63) | (64'd1 << 12) | (64'd1 << 11) | (64'd1 << 5) | 64'd1},
            '{OP_QUERY, 6'd21, 9'd300,    6'd42, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NO_SET},
            '{OP_QUERY, 6'd42, 9'd170,    6'd21, 64'h5555_5555_5555_5555, 1'b0, NO_SET},
            '{OP_ADD,   6'd62, EPS_RESET, 6'd1,  NO_SET,  1'b0, NO_SET},
            '{OP_QUERY, 6'd0,  9'd0,      6'd0,  64'd1 << 62, 1'b0, NO_SET}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].op, directed_rows[r].src, directed_rows[r].sym,
                      directed_rows[r].tgt, directed_rows[r].seed, directed_rows[r].typed,
                      directed_rows[r].closure);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    code = '0;
                end
                1: begin
                    code = '1;
                end
                4: begin
                    code = EPS_RESET;
                end
                default: begin
                    code = SYM_W'($urandom_range(0, 511));
                end
            endcase
            write_eps(code);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 30 == 0) begin
                    steady = ($urandom_range(0, 3) == 0);
                end
                src  = STATE_FIELD_W'($urandom_range(0, NUM_STATES - 1));
                sym  = SYM_W'($urandom_range(0, 511));
                tgt  = STATE_FIELD_W'($urandom_range(0, NUM_STATES - 1));
                seed = {$urandom, $urandom};
                if ($urandom_range(0, 99) < 45) begin
                    if ($urandom_range(0, 9) < 8 && src <= NUM_STATES - 4) begin
                        tgt = STATE_FIELD_W'(src + $urandom_range(1, 3));
                    end
                    if ($urandom_range(0, 99) < 65) begin
                        sym = eps_code;
                    end
                    send_item(OP_ADD, src, sym, tgt, seed, 1'b0, NO_SET);
                end else begin
                    kind = $urandom_range(0, 9);
                    if (kind == 0) begin
                        seed = $urandom_range(0, 1) ? ALL_SET : NO_SET;
                    end else if (kind <= 5) begin
                        seed = 64'd1 << $urandom_range(0, NUM_STATES - 1);
                    end else if (kind <= 7) begin
                        seed = (64'd1 << $urandom_range(0, NUM_STATES - 1)) |
                               (64'd1 << $urandom_range(0, NUM_STATES - 1));
                    end
                    send_item(OP_QUERY, src, sym, tgt, seed, 1'b0, NO_SET);
                end
            end
        end

        item_bus.valid <= 1'b0;
        while (pending_closures.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (pending_closures.size() != 0) begin
            $display("%0t: %0d closures never arrived", $time, pending_closures.size());
            mismatch_count++;
        end
        $display("Sent %0d items (%0d closure queries, %0d epsilon edge beats) under %0d codes.",
                 items_sent, queries_sent, eps_beats, codes_used);
        $display("Checked %0d closure results, %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("nfa_epsilon_closure test passed");
        end else begin
            $display("nfa_epsilon_closure test failed");
        end
        $finish;
    end

endmodule
